### rtl/core/ramr_pkg.sv
// ----------------------------------------------------------------------------
// ramr_pkg
// Shared widths, types and sign/magnitude helpers for the rational
// add/multiply/reduce core.
// ----------------------------------------------------------------------------
package ramr_pkg;

    // field widths
    localparam int FIELD_W = 32;
    localparam int WIDTH   = 32;
    localparam int DW      = 2 * WIDTH;
    localparam int SHIFT_W = $clog2(DW);
    localparam int CNT_W   = $clog2(DW);
    localparam int KIND_W  = 2;

    // operation codes; the unused code decodes as reduce
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 2'd0,
        KIND_MUL = 2'd1,
        KIND_RED = 2'd2
    } t_kind;

    // operand as sign and magnitude
    typedef struct packed {
        logic             neg;
        logic [WIDTH-1:0] mag;
    } t_sop;

    // double-width value as sign and magnitude
    typedef struct packed {
        logic          neg;
        logic [DW-1:0] mag;
    } t_sval;

    // split a two's complement field into sign and magnitude
    function automatic t_sop from_field(input logic [FIELD_W-1:0] f);
        logic [WIDTH-1:0] v;
        t_sop             r;
        v     = f[WIDTH-1:0];
        r.neg = v[WIDTH-1];
        r.mag = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
        return r;
    endfunction

    // true when the value fits signed WIDTH bits
    function automatic logic fits(input t_sval x);
        logic [DW-1:0] lim;
        lim            = '0;
        lim[WIDTH-1]   = 1'b1;
        return x.neg ? (x.mag <= lim) : (x.mag < lim);
    endfunction

    // low WIDTH bits of the two's complement value
    function automatic logic [WIDTH-1:0] to_field(input t_sval x);
        logic [DW-1:0] v;
        v = x.neg ? (~x.mag + DW'(1)) : x.mag;
        return v[WIDTH-1:0];
    endfunction

endpackage

### rtl/core/ramr_mul.sv
// ----------------------------------------------------------------------------
// ramr_mul
// Unsigned WIDTH x WIDTH multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module ramr_mul (
    input  logic                       i_clk,
    input  logic [ramr_pkg::WIDTH-1:0] i_a,
    input  logic [ramr_pkg::WIDTH-1:0] i_b,
    output logic [ramr_pkg::DW-1:0]    o_p
);
    import ramr_pkg::*;

    logic [DW-1:0] r_p;

    // product register
    always_ff @(posedge i_clk) begin
        r_p <= DW'(i_a) * DW'(i_b);
    end

    assign o_p = r_p;

endmodule

### rtl/core/ramr_gcd.sv
// ----------------------------------------------------------------------------
// ramr_gcd
// Binary greatest common divisor of two double-width magnitudes, one shift
// or one compare-and-subtract per cycle. The second operand is nonzero.
// ----------------------------------------------------------------------------
module ramr_gcd (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ramr_pkg::DW-1:0] i_u,
    input  logic [ramr_pkg::DW-1:0] i_v,
    output logic                    o_done,
    output logic [ramr_pkg::DW-1:0] o_g
);
    import ramr_pkg::*;

    typedef enum logic [4:0] {
        G_IDLE = 5'b00001,
        G_PAIR = 5'b00010,
        G_UODD = 5'b00100,
        G_LOOP = 5'b01000,
        G_OUT  = 5'b10000
    } t_gstate;

    t_gstate              r_state;
    logic                 r_done;
    logic [DW-1:0]        r_u;
    logic [DW-1:0]        r_v;
    logic [DW-1:0]        r_g;
    logic [SHIFT_W-1:0]   r_shift;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_shift <= '0;
                        r_v     <= i_v;
                        if (i_u == '0) begin
                            r_u     <= i_v;
                            r_state <= G_OUT;
                        end else begin
                            r_u     <= i_u;
                            r_state <= G_PAIR;
                        end
                    end
                end
                // strip common factors of two
                G_PAIR: begin
                    if (!(r_u[0] | r_v[0])) begin
                        r_u     <= r_u >> 1;
                        r_v     <= r_v >> 1;
                        r_shift <= r_shift + 1'b1;
                    end else begin
                        r_state <= G_UODD;
                    end
                end
                // make u odd
                G_UODD: begin
                    if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else begin
                        r_state <= G_LOOP;
                    end
                end
                // shift v odd, then subtract the smaller from the larger
                G_LOOP: begin
                    if (r_v == '0) begin
                        r_state <= G_OUT;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u > r_v) begin
                        r_u <= r_v;
                        r_v <= r_u - r_v;
                    end else begin
                        r_v <= r_v - r_u;
                    end
                end
                G_OUT: begin
                    r_g     <= r_u << r_shift;
                    r_done  <= 1'b1;
                    r_state <= G_IDLE;
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

    // a gcd run always starts from a nonzero second operand
    a_start_v_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && (r_state == G_IDLE) |-> i_v != '0)
        else $error("gcd started with zero second operand");

endmodule

### rtl/core/ramr_div.sv
// ----------------------------------------------------------------------------
// ramr_div
// Restoring divider for double-width magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ramr_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [ramr_pkg::DW-1:0] i_dividend,
    input  logic [ramr_pkg::DW-1:0] i_divisor,
    output logic                    o_done,
    output logic [ramr_pkg::DW-1:0] o_quot
);
    import ramr_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_q;
    logic [DW-1:0]     r_dsr;
    logic [DW:0]       rem_sh;
    logic [DW:0]       diff;
    logic              ge;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_q[DW-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        ge     = !diff[DW];
    end

    // iteration control and remainder/quotient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dsr  <= i_divisor;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    // divisor is the gcd, never zero
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !r_busy |-> i_divisor != '0)
        else $error("division started with zero divisor");

    // done pulses only at the end of a run
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

endmodule

### rtl/core/rational_add_mul_reduce_core.sv
// ----------------------------------------------------------------------------
// rational_add_mul_reduce_core
// Signed fraction add, multiply or reduce, with reduction by the gcd.
// ----------------------------------------------------------------------------
// One word is taken when start is high and busy is low; busy drops in the
// cycle its result word is driven, so the next word can be taken right then.
// The result appears on the result ports for
// a single cycle marked by o_done and cannot be held off, so it must be taken
// in that cycle. With a zero result denominator the result strobes as soon
// as the raw fraction is formed. Otherwise the run is product forming, then
// the binary gcd loop (one shift or subtract per cycle on 64-bit magnitudes),
// then two restoring divisions of the numerator and denominator by the gcd.
// The gcd loop and the one-bit-a-cycle divider set the length of a run; the
// single 32x32 multiplier is used three times.
// ----------------------------------------------------------------------------
module rational_add_mul_reduce_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ramr_pkg::KIND_W-1:0]  i_kind,
    input  logic [ramr_pkg::FIELD_W-1:0] i_a_num,
    input  logic [ramr_pkg::FIELD_W-1:0] i_a_den,
    input  logic [ramr_pkg::FIELD_W-1:0] i_b_num,
    input  logic [ramr_pkg::FIELD_W-1:0] i_b_den,
    output logic                         o_done,
    output logic [ramr_pkg::FIELD_W-1:0] o_res_num,
    output logic [ramr_pkg::FIELD_W-1:0] o_res_den,
    output logic                         o_overflow,
    output logic                         o_den_zero
);
    import ramr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_FORM = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIVN = 6'b010000,
        S_DIVD = 6'b100000
    } t_state;

    t_state              r_state;
    logic [1:0]          r_step;
    logic                r_done;
    t_kind               r_kind;
    t_sop                r_an;
    t_sop                r_ad;
    t_sop                r_bn;
    t_sop                r_bd;
    logic [DW-1:0]       r_p0;
    logic [DW-1:0]       r_p1;
    logic [DW-1:0]       r_g;
    t_sval               r_num;
    t_sval               r_den;
    logic [FIELD_W-1:0]  r_res_num;
    logic [FIELD_W-1:0]  r_res_den;
    logic                r_overflow;
    logic                r_den_zero;

    logic [WIDTH-1:0]    mul_a;
    logic [WIDTH-1:0]    mul_b;
    logic [DW-1:0]       mul_p;
    logic                gcd_start;
    logic                gcd_done;
    logic [DW-1:0]       gcd_g;
    logic                div_start;
    logic [DW-1:0]       div_dividend;
    logic [DW-1:0]       div_divisor;
    logic                div_done;
    logic [DW-1:0]       div_q;

    t_sval               t0;
    t_sval               t1;
    t_sval               sum;
    t_sval               num_fm;
    t_sval               den_fm;
    t_sval               den_red;
    logic [DW:0]         diff;

    // multiplier operand select per product step
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_an.mag;
                mul_b = (r_kind == KIND_MUL) ? r_bn.mag : r_bd.mag;
            end
            2'd1: begin
                mul_a = r_bn.mag;
                mul_b = r_ad.mag;
            end
            default: begin
                mul_a = r_ad.mag;
                mul_b = r_bd.mag;
            end
        endcase
    end

    ramr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // signed products, their sum, and the raw fraction
    always_comb begin
        t0.mag = r_p0;
        t0.neg = (r_p0 != '0)
               && (r_an.neg ^ ((r_kind == KIND_MUL) ? r_bn.neg : r_bd.neg));
        t1.mag = r_p1;
        t1.neg = (r_p1 != '0) && (r_bn.neg ^ r_ad.neg);
        diff   = {1'b0, r_p0} - {1'b0, r_p1};
        if (t0.neg == t1.neg) begin
            sum.mag = r_p0 + r_p1;
            sum.neg = t0.neg;
        end else if (!diff[DW]) begin
            sum.mag = diff[DW-1:0];
            sum.neg = t0.neg;
        end else begin
            sum.mag = ~diff[DW-1:0] + DW'(1);
            sum.neg = t1.neg;
        end
        if (sum.mag == '0) begin
            sum.neg = 1'b0;
        end
        case (r_kind)
            KIND_ADD: begin
                num_fm = sum;
                den_fm = r_den;
            end
            KIND_MUL: begin
                num_fm = t0;
                den_fm = r_den;
            end
            default: begin
                num_fm = '{neg: r_an.neg, mag: DW'(r_an.mag)};
                den_fm = '{neg: r_ad.neg, mag: DW'(r_ad.mag)};
            end
        endcase
        den_red = '{neg: r_den.neg, mag: div_q};
    end

    // gcd and divider hookup
    assign gcd_start    = (r_state == S_FORM) && (den_fm.mag != '0);
    assign div_start    = ((r_state == S_GCD) && gcd_done)
                        || ((r_state == S_DIVN) && div_done);
    assign div_dividend = (r_state == S_GCD) ? r_num.mag : r_den.mag;
    assign div_divisor  = (r_state == S_GCD) ? gcd_g : r_g;

    ramr_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_u     (num_fm.mag),
        .i_v     (den_fm.mag),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    ramr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind  <= t_kind'(i_kind);
                        r_an    <= from_field(i_a_num);
                        r_ad    <= from_field(i_a_den);
                        r_bn    <= from_field(i_b_num);
                        r_bd    <= from_field(i_b_den);
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end
                end
                // three products through the shared multiplier
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        2'd1: r_p0 <= mul_p;
                        2'd2: r_p1 <= mul_p;
                        2'd3: begin
                            r_den.mag <= mul_p;
                            r_den.neg <= (mul_p != '0) && (r_ad.neg ^ r_bd.neg);
                            r_state   <= S_FORM;
                        end
                        default: ;
                    endcase
                end
                // raw fraction; zero denominator ends here
                S_FORM: begin
                    r_num <= num_fm;
                    r_den <= den_fm;
                    if (den_fm.mag == '0) begin
                        r_res_num  <= FIELD_W'(to_field(num_fm));
                        r_res_den  <= '0;
                        r_overflow <= !fits(num_fm);
                        r_den_zero <= 1'b1;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (gcd_done) begin
                        r_g     <= gcd_g;
                        r_state <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    if (div_done) begin
                        r_num.mag <= div_q;
                        r_state   <= S_DIVD;
                    end
                end
                // reduced denominator arrives, drive the result word
                S_DIVD: begin
                    if (div_done) begin
                        r_res_num  <= FIELD_W'(to_field(r_num));
                        r_res_den  <= FIELD_W'(to_field(den_red));
                        r_overflow <= !(fits(r_num) && fits(den_red));
                        r_den_zero <= 1'b0;
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_overflow = r_overflow;
    assign o_den_zero = r_den_zero;

    // an accepted word keeps the core busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("core not busy after accepting a word");

    // the result strobe closes a run
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a run");

    // a zero denominator result carries a zero denominator field
    a_den_zero_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_den_zero |-> o_res_den == '0)
        else $error("zero denominator flag with nonzero denominator");

endmodule
